// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the URL locator RTL. Empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property at every rising clk edge outside of reset.
`define UCL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ucl assertion failed");
// Check that a condition never holds outside of reset.
`define UCL_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("ucl forbidden condition seen");
`else
`define UCL_ASSERT(lbl, prop)
`define UCL_NEVER(lbl, expr)
`endif
`endif

// ===== hdl/ucl_pkg.sv =====
// ---------------------------------------------------------------------------
// ucl_pkg
// Widths, character codes and match patterns for the URL component locator.
// ---------------------------------------------------------------------------
package ucl_pkg;

  localparam int MAX_LEN = 1024;
  localparam int POS_W   = $clog2(MAX_LEN + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [1:0] KIND_HTTPS = 2'd0;
  localparam logic [1:0] KIND_HTTP  = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  localparam logic [POS_W-1:0] HTTPS_LEN = POS_W'(8);
  localparam logic [POS_W-1:0] HTTP_LEN  = POS_W'(7);
  localparam logic [POS_W-1:0] WWW_LEN   = POS_W'(4);

  // www matcher codes: 0..3 = bytes matched so far
  localparam logic [2:0] WWW_DONE = 3'd4;
  localparam logic [2:0] WWW_FAIL = 3'd5;

  // separator matcher codes
  localparam logic [1:0] SEP_IDLE  = 2'd0;
  localparam logic [1:0] SEP_COLON = 2'd1;
  localparam logic [1:0] SEP_ONE   = 2'd2;
  localparam logic [1:0] SEP_DONE  = 2'd3;

  function automatic logic [7:0] https_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = "h";
      3'd1: c = "t";
      3'd2: c = "t";
      3'd3: c = "p";
      3'd4: c = "s";
      3'd5: c = ":";
      default: c = "/";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] http_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = "h";
      3'd1: c = "t";
      3'd2: c = "t";
      3'd3: c = "p";
      3'd4: c = ":";
      default: c = "/";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] www_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd3: c = ".";
      default: c = "w";
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/url_component_locator.sv =====
// ---------------------------------------------------------------------------
// url_component_locator
// Streams a URL one byte per word and reports protocol, www, domain and path
// offsets of the space-trimmed text on the word flagged last_byte.
// ---------------------------------------------------------------------------
// Takes one byte every clock cycle while in_stall is low: each byte is
// captured in an input register and then folded into the match state by
// one level of shallow compare logic. A URL's result is registered once its
// last byte leaves the input register, and is held in the result register
// on out_valid until taken. in_stall rises only while a last byte waits
// behind a result that is still stalled; ordinary bytes keep flowing under
// an output stall. Offsets saturate at MAX_LEN bytes; too_long flags excess.
`include "assert_macros.svh"

module url_component_locator
  import ucl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_ch,
  input  logic             in_last_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_protocol_kind,
  output logic             out_has_www,
  output logic [POS_W-1:0] out_domain_start,
  output logic [POS_W-1:0] out_domain_end,
  output logic [POS_W-1:0] out_path_start,
  output logic             out_path_found,
  output logic [POS_W-1:0] out_trimmed_length,
  output logic             out_secure,
  output logic             out_too_long
);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_ch_r;
  logic       s1_last_r;
  logic       in_accept;
  logic       s1_go;

  // match state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             seen_r, seen_nxt;
  logic [POS_W-1:0] last_end_r, last_end_nxt;
  logic [1:0]       prefix_r, prefix_nxt;
  logic [1:0]       sep_st_r, sep_st_nxt;
  logic             sep_found_r, sep_found_nxt;
  logic [POS_W-1:0] origin_r, origin_nxt;
  logic [2:0]       www_st_r, www_st_nxt;
  logic             www_r, www_nxt;
  logic [POS_W-1:0] slash_pos_r, slash_pos_nxt;
  logic             slash_r, slash_nxt;
  logic             ovf_r, ovf_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       kind_r;
  logic             has_www_r;
  logic [POS_W-1:0] dstart_r, dend_r, pstart_r, len_r;
  logic             pfound_r, secure_r, too_long_r;

  logic [7:0]       c_low;
  logic             is_space, take, room;
  logic [1:0]       sep_calc;
  logic [POS_W-1:0] pos_inc;
  logic [1:0]       kind_nxt;

  assign in_stall  = s1_valid_r && s1_last_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign s1_go     = s1_valid_r && !in_stall;

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    is_space = (s1_ch_r == CH_SPACE);
    c_low    = (s1_ch_r >= CH_UP_A && s1_ch_r <= CH_UP_Z) ? (s1_ch_r | CASE_BIT) : s1_ch_r;
    take     = !is_space || seen_r;
    room     = (pos_r < POS_W'(MAX_LEN));
    pos_inc  = pos_r + POS_W'(1);

    pos_nxt       = pos_r;
    seen_nxt      = seen_r || !is_space;
    last_end_nxt  = last_end_r;
    prefix_nxt    = prefix_r;
    sep_st_nxt    = sep_st_r;
    sep_found_nxt = sep_found_r;
    origin_nxt    = origin_r;
    www_st_nxt    = www_st_r;
    www_nxt       = www_r;
    slash_pos_nxt = slash_pos_r;
    slash_nxt     = slash_r;
    ovf_nxt       = ovf_r;
    sep_calc      = SEP_IDLE;

    if (take && room) begin
      if (pos_r < HTTPS_LEN && c_low != https_char(pos_r[2:0])) begin
        prefix_nxt[0] = 1'b1;
      end
      if (pos_r < HTTP_LEN && c_low != http_char(pos_r[2:0])) begin
        prefix_nxt[1] = 1'b1;
      end

      if (www_st_r < WWW_DONE) begin
        if (c_low == www_char(www_st_r[1:0])) begin
          www_st_nxt = www_st_r + 3'd1;
          if (www_st_r == WWW_DONE - 3'd1) begin
            www_nxt = 1'b1;
          end
        end else begin
          www_st_nxt = WWW_FAIL;
        end
      end

      if (!slash_r && c_low == CH_SLASH) begin
        slash_nxt     = 1'b1;
        slash_pos_nxt = pos_r;
      end

      if (!sep_found_r) begin
        if (c_low == CH_COLON) begin
          sep_calc = SEP_COLON;
        end else if (c_low == CH_SLASH && sep_st_r == SEP_COLON) begin
          sep_calc = SEP_ONE;
        end else if (c_low == CH_SLASH && sep_st_r == SEP_ONE) begin
          sep_calc = SEP_DONE;
        end
        if (sep_calc == SEP_DONE) begin
          // restart host search after the separator
          sep_found_nxt = 1'b1;
          sep_st_nxt    = SEP_IDLE;
          origin_nxt    = pos_inc;
          www_st_nxt    = 3'd0;
          www_nxt       = 1'b0;
          slash_nxt     = 1'b0;
          slash_pos_nxt = '0;
        end else begin
          sep_st_nxt = sep_calc;
        end
      end

      pos_nxt = pos_inc;
      if (!is_space) begin
        last_end_nxt = pos_inc;
      end
    end else if (take && !is_space) begin
      ovf_nxt = 1'b1;
    end

    if (last_end_nxt >= HTTPS_LEN && !prefix_nxt[0]) begin
      kind_nxt = KIND_HTTPS;
    end else if (last_end_nxt >= HTTP_LEN && !prefix_nxt[1]) begin
      kind_nxt = KIND_HTTP;
    end else begin
      kind_nxt = KIND_NONE;
    end
  end

  always_comb begin
    if (s1_go && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last_byte;
    end
  end

  // match state: advance per byte, clear after the last byte of a URL
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_go && s1_last_r)) begin
      pos_r       <= '0;
      seen_r      <= 1'b0;
      last_end_r  <= '0;
      prefix_r    <= 2'b00;
      sep_st_r    <= SEP_IDLE;
      sep_found_r <= 1'b0;
      origin_r    <= '0;
      www_st_r    <= 3'd0;
      www_r       <= 1'b0;
      slash_pos_r <= '0;
      slash_r     <= 1'b0;
      ovf_r       <= 1'b0;
    end else if (s1_go) begin
      pos_r       <= pos_nxt;
      seen_r      <= seen_nxt;
      last_end_r  <= last_end_nxt;
      prefix_r    <= prefix_nxt;
      sep_st_r    <= sep_st_nxt;
      sep_found_r <= sep_found_nxt;
      origin_r    <= origin_nxt;
      www_st_r    <= www_st_nxt;
      www_r       <= www_nxt;
      slash_pos_r <= slash_pos_nxt;
      slash_r     <= slash_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      kind_r     <= kind_nxt;
      has_www_r  <= www_nxt;
      dstart_r   <= www_nxt ? (origin_nxt + WWW_LEN) : origin_nxt;
      dend_r     <= slash_nxt ? slash_pos_nxt : last_end_nxt;
      pstart_r   <= slash_nxt ? slash_pos_nxt : '0;
      pfound_r   <= slash_nxt;
      len_r      <= last_end_nxt;
      secure_r   <= (kind_nxt == KIND_HTTPS) && www_nxt;
      too_long_r <= ovf_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_protocol_kind  = kind_r;
  assign out_has_www        = has_www_r;
  assign out_domain_start   = dstart_r;
  assign out_domain_end     = dend_r;
  assign out_path_start     = pstart_r;
  assign out_path_found     = pfound_r;
  assign out_trimmed_length = len_r;
  assign out_secure         = secure_r;
  assign out_too_long       = too_long_r;

  `UCL_ASSERT(a_stall_only_on_last, in_stall |-> (s1_valid_r && s1_last_r && out_valid_r))
  `UCL_ASSERT(a_result_after_last, $rose(out_valid) |-> $past(s1_go && s1_last_r))
  `UCL_ASSERT(a_pos_covers_end, last_end_r <= pos_r && pos_r <= POS_W'(MAX_LEN))
  `UCL_ASSERT(a_path_in_text, (out_valid && out_path_found) |-> out_path_start < out_trimmed_length)
  `UCL_NEVER(a_sep_state_range, sep_st_r == SEP_DONE)
  `UCL_ASSERT(a_secure_means_https, (out_valid && out_secure) |-> (out_protocol_kind == KIND_HTTPS && out_has_www))

endmodule
